// File: rtl/imd_pkg.sv
// Package for the integer matrix determinant block.
// Holds the entry width and the datapath command type.
`default_nettype none
package imd_pkg;
    localparam int DATA_W = 32;
    localparam int SIZE_W = 4;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd3;
    localparam logic [SIZE_W-1:0] SIZE_MIN = 4'd2;

    typedef struct packed {
        logic load;
        logic clear_acc;
        logic acc_go;
        logic store_sub;
    } imd_cmd_t;
endpackage
`default_nettype wire

// File: rtl/imd_datapath.sv
// Datapath of the determinant block: matrix store, sub-determinant store,
// one 32x32 multiplier and accumulator. Uses imd_pkg.
`default_nettype none
module imd_datapath
    import imd_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  wire logic              clk,
    input  wire imd_cmd_t          cmd,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0] load_addr,
    input  wire logic [DATA_W-1:0] load_data,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0] mat_addr,
    input  wire logic [MAX_DIM-1:0] sub_addr,
    input  wire logic [MAX_DIM-1:0] wr_mask,
    input  wire logic              negate,
    output logic [DATA_W-1:0]      acc
);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int SUBS  = 1 << MAX_DIM;

    logic [DATA_W-1:0] mat_mem [DEPTH];
    logic [DATA_W-1:0] sub_mem [SUBS];
    logic [DATA_W-1:0] mat_rd_reg;
    logic [DATA_W-1:0] sub_rd_reg;
    logic [DATA_W-1:0] prod_reg;
    logic              neg_reg;
    logic              neg_d_reg;
    logic [DATA_W-1:0] acc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mat_mem[load_addr] <= load_data;
        end
        mat_rd_reg <= mat_mem[mat_addr];
    end

    // mask 0 reads as one: the empty determinant
    always_ff @(posedge clk)
    begin
        if (cmd.store_sub)
        begin
            sub_mem[wr_mask] <= acc_reg;
        end
        if (sub_addr == '0)
        begin
            sub_rd_reg <= DATA_W'(1);
        end
        else
        begin
            sub_rd_reg <= sub_mem[sub_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= negate;
        neg_d_reg <= neg_reg;
        prod_reg  <= mat_rd_reg * sub_rd_reg;
        if (cmd.clear_acc)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_go)
        begin
            acc_reg <= neg_d_reg ? acc_reg - prod_reg : acc_reg + prod_reg;
        end
    end

    assign acc = acc_reg;
endmodule
`default_nettype wire

// File: rtl/imd_controller.sv
// Controller of the determinant block: load counting, mask and column
// sequencing, result strobe. Uses imd_pkg; drives imd_datapath.
`default_nettype none
module imd_controller
    import imd_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              cfg_write,
    input  wire logic [SIZE_W-1:0] size_raw,
    output logic                   busy,
    output logic                   done,
    output imd_cmd_t               cmd,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] load_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] mat_addr,
    output logic [MAX_DIM-1:0]     sub_addr,
    output logic [MAX_DIM-1:0]     wr_mask,
    output logic                   negate
);
    localparam int AW = $clog2(MAX_DIM*MAX_DIM);
    localparam int CW = $clog2(MAX_DIM);
    localparam int NW = $clog2(MAX_DIM+1);
    localparam int DW = $clog2(MAX_DIM*MAX_DIM+1);

    typedef enum logic [2:0] {S_LOAD, S_MASK, S_COL, S_DRAIN, S_STORE, S_DONE} state_t;

    state_t            state_reg;
    logic [DW-1:0]     count_reg;
    logic [MAX_DIM-1:0] mask_reg;
    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     row_reg;
    logic              above_reg;
    logic [1:0]        drain_reg;
    logic [NW-1:0]     n;
    logic [DW-1:0]     total;
    logic [MAX_DIM-1:0] full;
    logic              bit_in;
    logic [NW-1:0]     pop;

    always_comb
    begin
        if (size_raw < SIZE_MIN)
        begin
            n = NW'(SIZE_MIN);
        end
        else if (32'(size_raw) > MAX_DIM)
        begin
            n = NW'(MAX_DIM);
        end
        else
        begin
            n = NW'(size_raw);
        end
        total = DW'(32'(n) * 32'(n));
        full = MAX_DIM'((1 << n) - 1);
        bit_in = mask_reg[col_reg];
        pop = '0;
        for (int i = 0; i < MAX_DIM; i++)
        begin
            pop = pop + NW'(mask_reg[i]);
        end
    end

    assign busy = (state_reg != S_LOAD);
    assign load_addr = count_reg[AW-1:0];
    assign mat_addr = AW'(32'(row_reg) * 32'(n) + 32'(col_reg));
    assign sub_addr = mask_reg & ~(MAX_DIM'(1) << col_reg);
    assign wr_mask = mask_reg;
    assign negate = above_reg;

    always_comb
    begin
        cmd = '0;
        cmd.load = start && !busy;
        cmd.clear_acc = (state_reg == S_MASK);
        cmd.acc_go = (state_reg == S_DRAIN) && (drain_reg == 2'd0);
        cmd.store_sub = (state_reg == S_STORE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            mask_reg  <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            above_reg <= 1'b0;
            drain_reg <= '0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (cfg_write)
                    begin
                        count_reg <= '0;
                    end
                    else if (start)
                    begin
                        if (count_reg + DW'(1) >= total)
                        begin
                            count_reg <= '0;
                            mask_reg  <= MAX_DIM'(1);
                            state_reg <= S_MASK;
                        end
                        else
                        begin
                            count_reg <= count_reg + DW'(1);
                        end
                    end
                end
                S_MASK:
                begin
                    row_reg   <= CW'(pop - NW'(1));
                    col_reg   <= CW'(n - NW'(1));
                    above_reg <= 1'b0;
                    state_reg <= S_COL;
                end
                // one column per cycle unless set: its term drains into acc first
                S_COL:
                begin
                    if (bit_in)
                    begin
                        drain_reg <= 2'd3;
                        state_reg <= S_DRAIN;
                    end
                    else if (col_reg == '0)
                    begin
                        state_reg <= S_STORE;
                    end
                    else
                    begin
                        col_reg <= col_reg - CW'(1);
                    end
                end
                S_DRAIN:
                begin
                    if (drain_reg == 2'd0)
                    begin
                        above_reg <= ~above_reg;
                        if (col_reg == '0)
                        begin
                            state_reg <= S_STORE;
                        end
                        else
                        begin
                            col_reg   <= col_reg - CW'(1);
                            state_reg <= S_COL;
                        end
                    end
                    else
                    begin
                        drain_reg <= drain_reg - 2'd1;
                    end
                end
                S_STORE:
                begin
                    if (mask_reg == full)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        mask_reg  <= mask_reg + MAX_DIM'(1);
                        state_reg <= S_MASK;
                    end
                end
                S_DONE:
                begin
                    done      <= 1'b1;
                    state_reg <= S_LOAD;
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/integer_matrix_determinant.sv
// Top level of the integer matrix determinant block.
// Holds the size register; joins imd_controller and imd_datapath. Uses imd_pkg.
//
// Entries are taken one a cycle, row-major, while busy is low. After the
// last entry busy rises while the sub-determinant sweep runs over all 2^n - 1
// column masks; each set column goes through the multiply and accumulate
// loop and its drain, each clear column is stepped past, and every mask also
// passes the S_MASK clear step and the S_STORE store step, in that order.
// det_strobe marks the result for one cycle and cannot be held off. A size
// transfer is taken only while busy is low and no entry is offered.
`default_nettype none
module integer_matrix_determinant
    import imd_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic signed [DATA_W-1:0] entry_value,
    output logic                   det_strobe,
    output logic signed [DATA_W-1:0] det_value,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [SIZE_W-1:0] cfg_data
);
    localparam int AW = $clog2(MAX_DIM*MAX_DIM);

    logic [SIZE_W-1:0] size_reg;
    imd_cmd_t          cmd;
    logic [AW-1:0]     load_addr;
    logic [AW-1:0]     mat_addr;
    logic [MAX_DIM-1:0] sub_addr;
    logic [MAX_DIM-1:0] wr_mask;
    logic              negate;
    logic [DATA_W-1:0] acc;
    logic              cfg_write;

    assign cfg_ready = !busy && !start;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_write)
        begin
            size_reg <= cfg_data;
        end
    end

    imd_controller #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_write (cfg_write),
        .size_raw  (size_reg),
        .busy      (busy),
        .done      (det_strobe),
        .cmd       (cmd),
        .load_addr (load_addr),
        .mat_addr  (mat_addr),
        .sub_addr  (sub_addr),
        .wr_mask   (wr_mask),
        .negate    (negate)
    );

    imd_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .load_addr (load_addr),
        .load_data (entry_value),
        .mat_addr  (mat_addr),
        .sub_addr  (sub_addr),
        .wr_mask   (wr_mask),
        .negate    (negate),
        .acc       (acc)
    );

    assign det_value = acc;
endmodule
`default_nettype wire

// File: rtl/imd_checker.sv
// Port-level checker for integer_matrix_determinant, bound to the top level.
// Depends on imd_pkg.
`default_nettype none
module imd_port_checker
    import imd_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic det_strobe,
    input wire logic cfg_ready
);
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        det_strobe |=> !det_strobe) else $error("result strobe repeated");
    a_strobe_frees: assert property (@(posedge clk) disable iff (!rst_n)
        det_strobe |=> !busy) else $error("busy after result transfer");
    a_busy_ends_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        det_strobe |-> $past(busy)) else $error("result without computation");
    a_busy_after_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && !busy)) else $error("busy without entry transfer");
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready == (!busy && !start)) else $error("config ready while occupied");
endmodule

bind integer_matrix_determinant imd_port_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .det_strobe(det_strobe), .cfg_ready(cfg_ready)
);
`default_nettype wire
